// ----- rtl/alep_pkg.sv -----
// Shared types, constants and the control store of the eviction pool sequencer.
// No dependencies; used by the pool top level, its checker and the testbench.
`timescale 1ns / 1ps

package alep_pkg;

  localparam int POOL_SLOTS_DEF = 16;
  localparam int KEY_W          = 32;
  localparam int IDLE_W         = 48;
  localparam int ENTRY_W        = KEY_W + IDLE_W;
  localparam int COUNT_W        = 5;
  localparam int IN_DATA_W      = 80;
  localparam int OUT_DATA_W     = 40;

  // output word bit positions
  localparam int OUT_VVALID_LSB = 0;
  localparam int OUT_VKEY_LSB   = 1;
  localparam int OUT_TAKEN_LSB  = OUT_VKEY_LSB + KEY_W;
  localparam int OUT_COUNT_LSB  = OUT_TAKEN_LSB + 1;

  typedef enum logic [3:0] {
    U_EMIT   = 4'd0,
    U_WAIT   = 4'd1,
    U_DISP   = 4'd2,
    U_OFR    = 4'd3,
    U_DN0    = 4'd4,
    U_DN     = 4'd5,
    U_INS    = 4'd6,
    U_UP0    = 4'd7,
    U_UP     = 4'd8,
    U_UPFIN  = 4'd9,
    U_INS_LO = 4'd10,
    U_TAKE   = 4'd11,
    U_TK     = 4'd12
  } upc_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_WAIT,
    A_DN_SETUP,
    A_SHIFT_DN,
    A_INS,
    A_UP_SETUP,
    A_SHIFT_UP,
    A_INS_LO,
    A_TK_SETUP,
    A_TAKE,
    A_EMIT
  } ucode_act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACC,
    C_TAKE,
    C_FULL,
    C_EMPTY,
    C_DN_MORE,
    C_UP_MORE,
    C_PTR0,
    C_NO_VICTIM,
    C_OUT_BUSY
  } ucode_cond_t;

  typedef struct packed {
    ucode_act_t  act;
    ucode_cond_t cond;
    upc_t        tgt;
  } ucode_word_t;

  // next step = cond true ? tgt : step + 1
  function automatic ucode_word_t ucode_rom(input upc_t pc);
    ucode_word_t w;
    case (pc)
      U_EMIT:   w = '{A_EMIT,     C_OUT_BUSY,  U_EMIT};
      U_WAIT:   w = '{A_WAIT,     C_NO_ACC,    U_WAIT};
      U_DISP:   w = '{A_NONE,     C_TAKE,      U_TAKE};
      U_OFR:    w = '{A_NONE,     C_FULL,      U_UP0};
      U_DN0:    w = '{A_DN_SETUP, C_EMPTY,     U_INS};
      U_DN:     w = '{A_SHIFT_DN, C_DN_MORE,   U_DN};
      U_INS:    w = '{A_INS,      C_ALWAYS,    U_EMIT};
      U_UP0:    w = '{A_UP_SETUP, C_NEVER,     U_EMIT};
      U_UP:     w = '{A_SHIFT_UP, C_UP_MORE,   U_UP};
      U_UPFIN:  w = '{A_NONE,     C_PTR0,      U_EMIT};
      U_INS_LO: w = '{A_INS_LO,   C_ALWAYS,    U_EMIT};
      U_TAKE:   w = '{A_TK_SETUP, C_NO_VICTIM, U_EMIT};
      U_TK:     w = '{A_TAKE,     C_ALWAYS,    U_EMIT};
      default:  w = '{A_NONE,     C_ALWAYS,    U_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/alep_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module alep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/approx_lru_eviction_pool.sv -----
// Sampled-LRU eviction pool: a microcoded sequencer walking a sorted candidate RAM.
// Depends on alep_pkg and alep_ram.
`timescale 1ns / 1ps

// One word in, one word out. Candidates sit packed at the low end of a RAM,
// sorted by ascending idle time. An offer walks the RAM one entry per cycle
// through its read port and its write port, moving entries aside as it goes:
// from the top down when there is a free slot, from the bottom up when the
// pool is full (the least idle entry falls off). A sample that is no more idle
// than any entry of a full pool is dropped. A take removes the most idle entry
// from the top. Each word then reaches the emit step, which loads the result
// word into the output register and waits while downstream still holds the
// previous result. The next word is taken once the result is in that register,
// even if downstream has not taken it yet. No clearing pass after reset: the
// occupancy count alone marks which entries are live.

module approx_lru_eviction_pool #(
  parameter int POOL_SLOTS = alep_pkg::POOL_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic                            cfg_wdata,  // eviction_enabled
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [alep_pkg::IN_DATA_W-1:0]  s_tdata,    // key_id[31:0], idle_time[79:32]
  input  logic                            s_tuser,    // func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [alep_pkg::OUT_DATA_W-1:0] m_tdata     // victim_valid[0], victim_key[32:1],
                                                      // sample_taken[33], pool_count[38:34]
);

  localparam int AW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam int EW = alep_pkg::ENTRY_W;
  localparam int KW = alep_pkg::KEY_W;
  localparam int IW = alep_pkg::IDLE_W;

  alep_pkg::upc_t        upc, upc_next;
  alep_pkg::ucode_word_t cw;

  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic          en;

  logic          in_func;
  logic [KW-1:0] in_key;
  logic [IW-1:0] in_idle;

  logic          res_vvalid;
  logic [KW-1:0] res_vkey;
  logic          res_taken;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] ptr_m1, ptr_m2, ptr_p1, cnt_m1;
  logic [IW-1:0] rd_idle;
  logic          ge, lt, cond_hit, out_free;

  assign cw       = alep_pkg::ucode_rom(upc);
  assign s_tready = (cw.act == alep_pkg::A_WAIT);
  assign out_free = !m_tvalid || m_tready;

  assign ptr_m1  = ptr - CW'(1);
  assign ptr_m2  = ptr - CW'(2);
  assign ptr_p1  = ptr + CW'(1);
  assign cnt_m1  = count - CW'(1);
  assign rd_idle = ram_rdata[EW-1:KW];
  assign ge      = (rd_idle >= in_idle);
  assign lt      = !ge;

  // condition select and step sequencing
  always_comb begin
    cond_hit = 1'b0;
    case (cw.cond)
      alep_pkg::C_NEVER:     cond_hit = 1'b0;
      alep_pkg::C_ALWAYS:    cond_hit = 1'b1;
      alep_pkg::C_NO_ACC:    cond_hit = !s_tvalid;
      alep_pkg::C_TAKE:      cond_hit = in_func;
      alep_pkg::C_FULL:      cond_hit = (count == CW'(POOL_SLOTS));
      alep_pkg::C_EMPTY:     cond_hit = (count == '0);
      alep_pkg::C_DN_MORE:   cond_hit = ge && (ptr != CW'(1));
      alep_pkg::C_UP_MORE:   cond_hit = lt && (ptr != CW'(POOL_SLOTS - 1));
      alep_pkg::C_PTR0:      cond_hit = (ptr == '0);
      alep_pkg::C_NO_VICTIM: cond_hit = !en || (count == '0);
      alep_pkg::C_OUT_BUSY:  cond_hit = !out_free;
      default:               cond_hit = 1'b0;
    endcase
    upc_next = cond_hit ? cw.tgt : alep_pkg::upc_t'(upc + 4'd1);
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr[AW-1:0];
    case (cw.act)
      alep_pkg::A_DN_SETUP: ram_raddr = cnt_m1[AW-1:0];
      alep_pkg::A_SHIFT_DN: begin
        ram_we    = ge;
        ram_raddr = ptr_m2[AW-1:0];
      end
      alep_pkg::A_INS: begin
        ram_we    = 1'b1;
        ram_wdata = {in_idle, in_key};
      end
      alep_pkg::A_UP_SETUP: ram_raddr = '0;
      alep_pkg::A_SHIFT_UP: begin
        ram_we    = lt && (ptr != '0);
        ram_waddr = ptr_m1[AW-1:0];
        ram_raddr = ptr_p1[AW-1:0];
      end
      alep_pkg::A_INS_LO: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_m1[AW-1:0];
        ram_wdata = {in_idle, in_key};
      end
      alep_pkg::A_TK_SETUP: ram_raddr = cnt_m1[AW-1:0];
      default: ;
    endcase
  end

  alep_ram #(
    .WIDTH(EW),
    .DEPTH(POOL_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      upc      <= alep_pkg::U_WAIT;
      count    <= '0;
      en       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (cfg_wen) begin
        en <= cfg_wdata;
      end
      if ((cw.act == alep_pkg::A_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cw.act)
        alep_pkg::A_INS:  count <= count + CW'(1);
        alep_pkg::A_TAKE: count <= cnt_m1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cw.act)
      alep_pkg::A_WAIT: begin
        if (s_tvalid) begin
          in_func    <= s_tuser;
          in_key     <= s_tdata[KW-1:0];
          in_idle    <= s_tdata[KW+IW-1:KW];
          res_vvalid <= 1'b0;
          res_vkey   <= '0;
          res_taken  <= 1'b0;
        end
      end
      alep_pkg::A_DN_SETUP: ptr <= count;
      alep_pkg::A_SHIFT_DN: begin
        if (ge) begin
          ptr <= ptr_m1;
        end
      end
      alep_pkg::A_UP_SETUP: ptr <= '0;
      alep_pkg::A_SHIFT_UP: begin
        if (lt) begin
          ptr <= ptr_p1;
        end
      end
      alep_pkg::A_INS, alep_pkg::A_INS_LO: res_taken <= 1'b1;
      alep_pkg::A_TAKE: begin
        res_vvalid <= 1'b1;
        res_vkey   <= ram_rdata[KW-1:0];
      end
      alep_pkg::A_EMIT: begin
        if (out_free) begin
          m_tdata <= {1'b0, alep_pkg::COUNT_W'(count), res_taken, res_vkey, res_vvalid};
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/alep_chk.sv -----
// Port-level checker for the eviction pool, bound to the top level.
// Depends on alep_pkg and approx_lru_eviction_pool.
`timescale 1ns / 1ps

module alep_chk #(
  parameter int POOL_SLOTS = alep_pkg::POOL_SLOTS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [alep_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic                         vvalid, taken;
  logic [alep_pkg::KEY_W-1:0]   vkey;
  logic [alep_pkg::COUNT_W-1:0] pcount;

  assign vvalid = m_tdata[alep_pkg::OUT_VVALID_LSB];
  assign vkey   = m_tdata[alep_pkg::OUT_VKEY_LSB +: alep_pkg::KEY_W];
  assign taken  = m_tdata[alep_pkg::OUT_TAKEN_LSB];
  assign pcount = m_tdata[alep_pkg::OUT_COUNT_LSB +: alep_pkg::COUNT_W];

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no back-to-back accepts
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(vvalid && taken))
    else $error("victim and taken sample in one result");

  a_no_victim_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !vvalid |-> vkey == '0)
    else $error("victim key nonzero without a victim");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (POOL_SLOTS > 31) || (32'(pcount) <= POOL_SLOTS))
    else $error("pool count above pool size");

endmodule

bind approx_lru_eviction_pool alep_chk #(.POOL_SLOTS(POOL_SLOTS)) u_alep_chk (.*);

// ----- verif/approx_lru_eviction_pool_test.sv -----
// Self-checking testbench for approx_lru_eviction_pool: directed table, then random phases
// with source gaps and sink stalls, every result word checked against the table or a pool model.
// Depends on alep_pkg and the pool RTL.
`timescale 1ns / 1ps

module approx_lru_eviction_pool_test;

  localparam int KEY_W   = alep_pkg::KEY_W;
  localparam int IDLE_W  = alep_pkg::IDLE_W;
  localparam int COUNT_W = alep_pkg::COUNT_W;
  localparam int SLOTS = alep_pkg::POOL_SLOTS_DEF;
  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_TAKE  = 1'b1;
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 250;

  typedef struct packed {
    logic               vvalid;
    logic [KEY_W-1:0]   vkey;
    logic               taken;
    logic [COUNT_W-1:0] count;
  } pool_result_t;

  typedef struct {
    bit                is_cfg;
    bit                cfg_val;
    logic              fn;
    logic [KEY_W-1:0]  key;
    logic [IDLE_W-1:0] idle;
    bit                typed;
    pool_result_t      want;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wen = 1'b0;
  logic                            cfg_wdata = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [alep_pkg::IN_DATA_W-1:0]  s_tdata = '0;     // key_id[31:0], idle_time[79:32]
  logic                            s_tuser = 1'b0;   // func
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [alep_pkg::OUT_DATA_W-1:0] m_tdata;          // victim_valid[0], victim_key[32:1],
                                                     // sample_taken[33], pool_count[38:34]

  // model state
  logic [KEY_W-1:0]  pool_keys  [SLOTS];
  logic [IDLE_W-1:0] pool_idles [SLOTS];
  bit                pool_live  [SLOTS];
  bit                evict_on = 1'b0;

  pool_result_t result_q [$];
  plan_row_t    plan [$];
  int           fails = 0;
  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;

  approx_lru_eviction_pool #(
    .POOL_SLOTS(SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic pool_result_t res(logic vv, logic [KEY_W-1:0] vk, logic tk,
                                       logic [COUNT_W-1:0] cnt);
    pool_result_t r;
    r.vvalid = vv;
    r.vkey   = vk;
    r.taken  = tk;
    r.count  = cnt;
    return r;
  endfunction

  function automatic void move_slot(int dst, int src);
    pool_keys[dst]  = pool_keys[src];
    pool_idles[dst] = pool_idles[src];
    pool_live[dst]  = pool_live[src];
  endfunction

  // Applies one word to the pool model and returns the result word it should produce.
  function automatic pool_result_t pool_step(logic fn, logic [KEY_W-1:0] key,
                                             logic [IDLE_W-1:0] idle);
    pool_result_t r;
    int pos;
    int top;
    int cnt;
    r = '0;
    if (fn == FUNC_OFFER) begin
      pos = 0;
      while (pos < SLOTS && pool_live[pos] && pool_idles[pos] < idle) pos++;
      // full pool and the sample is the least idle: dropped
      if (!(pos == 0 && pool_live[SLOTS-1])) begin
        r.taken = 1'b1;
        if (pool_live[SLOTS-1]) begin
          // full: slot 0 falls off, lower entries move down
          pos--;
          for (int i = 0; i < pos; i++) move_slot(i, i + 1);
        end else begin
          for (int i = SLOTS - 1; i > pos; i--) move_slot(i, i - 1);
        end
        pool_keys[pos]  = key;
        pool_idles[pos] = idle;
        pool_live[pos]  = 1'b1;
      end
    end else if (evict_on) begin
      top = SLOTS - 1;
      while (top >= 0 && !pool_live[top]) top--;
      if (top >= 0) begin
        r.vvalid = 1'b1;
        r.vkey   = pool_keys[top];
        for (int i = top; i < SLOTS - 1; i++) move_slot(i, i + 1);
        pool_live[SLOTS-1] = 1'b0;
      end
    end
    cnt = 0;
    for (int i = 0; i < SLOTS; i++) cnt += pool_live[i];
    r.count = cnt[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    pool_result_t got;
    pool_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.vvalid = m_tdata[alep_pkg::OUT_VVALID_LSB];
      got.vkey   = m_tdata[alep_pkg::OUT_VKEY_LSB +: KEY_W];
      got.taken  = m_tdata[alep_pkg::OUT_TAKEN_LSB];
      got.count  = m_tdata[alep_pkg::OUT_COUNT_LSB +: COUNT_W];
      if (result_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result word with none pending: %h", $time, m_tdata);
      end else begin
        want = result_q.pop_front();
        if (got.vvalid !== want.vvalid || got.vkey !== want.vkey ||
            got.taken !== want.taken || got.count !== want.count) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result mismatch exp vv=%b key=%h taken=%b cnt=%0d,",
                     $time, want.vvalid, want.vkey, want.taken, want.count,
                     " got vv=%b key=%h taken=%b cnt=%0d",
                     got.vvalid, got.vkey, got.taken, got.count);
        end
      end
    end
  end

  function automatic void plan_word(logic fn, logic [KEY_W-1:0] key, logic [IDLE_W-1:0] idle,
                                    bit typed = 1'b0, pool_result_t want = '0);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_val = 1'b0;
    r.fn      = fn;
    r.key     = key;
    r.idle    = idle;
    r.typed   = typed;
    r.want    = want;
    plan.push_back(r);
  endfunction

  function automatic void plan_cfg(bit v);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    plan.push_back(r);
  endfunction

  task automatic send_word(input logic fn, input logic [KEY_W-1:0] key,
                           input logic [IDLE_W-1:0] idle, input bit typed,
                           input pool_result_t want);
    pool_result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {idle, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = pool_step(fn, key, idle);
    result_q.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    evict_on = v;
  endtask

  initial begin : stimulus
    int                take_pct;
    logic              fn;
    logic [KEY_W-1:0]  key;
    logic [IDLE_W-1:0] idle;
    bit                phase_en   [PHASES];
    int                phase_src  [PHASES];
    int                phase_sink [PHASES];

    phase_en   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_src  = '{0, 81, 0, 18, 0, 18};
    phase_sink = '{0, 0, 81, 18, 0, 81};

    for (int i = 0; i < SLOTS; i++) begin
      pool_keys[i]  = '0;
      pool_idles[i] = '0;
      pool_live[i]  = 1'b0;
    end

    // directed table
    plan_word(FUNC_TAKE, '1, IDLE_MAX, 1'b1, res(1'b0, '0, 1'b0, 5'd0));
    plan_word(FUNC_OFFER, 32'hFFFF_FFFF, IDLE_MAX, 1'b1, res(1'b0, '0, 1'b1, 5'd1));
    plan_word(FUNC_OFFER, 32'h0, '0, 1'b1, res(1'b0, '0, 1'b1, 5'd2));
    plan_word(FUNC_TAKE, '0, '0, 1'b1, res(1'b0, '0, 1'b0, 5'd2));
    plan_word(FUNC_OFFER, 32'h1, '0);                  // equal idle, goes ahead of key 0
    plan_cfg(1'b1);
    plan_word(FUNC_TAKE, '0, '0, 1'b1, res(1'b1, 32'hFFFF_FFFF, 1'b0, 5'd2));
    plan_word(FUNC_TAKE, '0, '0);
    plan_word(FUNC_TAKE, '0, '0);
    plan_word(FUNC_TAKE, '0, '0, 1'b1, res(1'b0, '0, 1'b0, 5'd0));
    // fill the pool, one duplicate key among them
    for (int i = 0; i < SLOTS; i++)
      plan_word(FUNC_OFFER, (i == 7) ? 32'h103 : 32'h100 + i, 48'h10_0000 * i + 1);
    plan_word(FUNC_OFFER, 32'hA5A5_A5A5, '0, 1'b1, res(1'b0, '0, 1'b0, 5'd16));
    plan_word(FUNC_OFFER, 32'h5A5A_5A5A, IDLE_MAX, 1'b1, res(1'b0, '0, 1'b1, 5'd16));
    plan_word(FUNC_TAKE, '0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[n]) begin
      if (plan[n].is_cfg)
        write_enable(plan[n].cfg_val);
      else
        send_word(plan[n].fn, plan[n].key, plan[n].idle, plan[n].typed, plan[n].want);
    end

    // random phases
    take_pct = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_enable(phase_en[p]);
      src_idle_pct   = phase_src[p];
      sink_stall_pct = phase_sink[p];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // runs that mostly fill, churn or empty the pool
        if (n % 20 == 0) begin
          case ($urandom_range(2))
            0:       take_pct = 10;
            1:       take_pct = 45;
            default: take_pct = 85;
          endcase
        end
        if ($urandom_range(63) == 0) drain_results();
        fn  = ($urandom_range(99) < take_pct) ? FUNC_TAKE : FUNC_OFFER;
        key = ($urandom_range(3) == 0) ? KEY_W'($urandom_range(3)) : $urandom();
        case ($urandom_range(3))
          0:       idle = IDLE_W'($urandom_range(7));      // ties
          1:       idle = IDLE_W'({$urandom(), $urandom()});
          2:       idle = $urandom_range(1) ? IDLE_MAX : '0;
          default: idle = IDLE_W'($urandom_range(65535));
        endcase
        send_word(fn, key, idle, 1'b0, '0);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fails == 0 && result_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/alep_pkg.sv
rtl/alep_ram.sv
rtl/approx_lru_eviction_pool.sv
rtl/alep_chk.sv
verif/approx_lru_eviction_pool_test.sv
